/* hdl/bcs_pkg.sv */
// Shared types, codes and fixed-point helpers for the bouncing circle sprite engine.
// Used by bcs_cell and bouncing_circle_sprite_engine; depends on nothing.
`default_nettype none

package bcs_pkg;

    // Default configuration
    localparam int CIRCLE_COUNT_DEF  = 3;
    localparam int SCREEN_COLS_DEF   = 80;
    localparam int SCREEN_ROWS_DEF   = 24;
    localparam int FRACTION_BITS_DEF = 8;

    // Internal widths, sized for the largest screen and fraction settings
    localparam int SW    = 21;  // signed span / position arithmetic
    localparam int D_W   = 21;  // signed pixel-to-center distance
    localparam int SQ_W  = 2 * D_W;
    localparam int CR_W  = 10;  // ceil(radius) in whole pixels
    localparam int CMP_W = 46;  // squared distance vs. squared limit

    localparam logic signed [SW-1:0] SAT_HI = SW'(32767);
    localparam logic signed [SW-1:0] SAT_LO = -SW'(32768);

    typedef enum logic [1:0] {
        OP_QUERY = 2'd0,
        OP_TICK  = 2'd1,
        OP_LOAD  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // Command broadcast from the controller to every cell
    typedef struct packed {
        logic               query;
        logic               load;
        logic               bounce;
        logic               advance;
        logic [6:0]         col;
        logic [4:0]         row;
        logic [1:0]         slot;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [12:0]        radius;
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
    } cmd_t;

    // Hit word handed from cell to cell
    typedef struct packed {
        logic       found;
        logic [1:0] idx;
    } hit_t;

    typedef struct packed {
        logic signed [15:0] pos;
        logic signed [15:0] vel;
    } axis_t;

    // Saturate a wide signed value to 16 bits
    function automatic logic signed [15:0] sat16(input logic signed [SW-1:0] x);
        logic signed [15:0] r;
        if (x > SAT_HI) begin
            r = 16'sh7FFF;
        end else if (x < SAT_LO) begin
            r = 16'sh8000;
        end else begin
            r = x[15:0];
        end
        return r;
    endfunction

    // Negate with saturation
    function automatic logic signed [15:0] neg_sat16(input logic signed [15:0] v);
        logic signed [15:0] r;
        if (v == 16'sh8000) begin
            r = 16'sh7FFF;
        end else begin
            r = -v;
        end
        return r;
    endfunction

    // Reflect off the low wall, then the high wall; the high-wall test uses the position after the low-wall reflection
    function automatic axis_t bounce(input logic signed [15:0] pos,
                                     input logic signed [15:0] vel,
                                     input logic [12:0]        rad,
                                     input logic signed [SW-1:0] span);
        logic signed [SW-1:0] p;
        logic signed [SW-1:0] r;
        logic signed [SW-1:0] hi_sum;
        logic                 low;
        logic                 high;
        logic signed [15:0]   v1;
        axis_t                res;
        p      = SW'(pos);
        r      = SW'(rad);
        low    = (p - r) <= SW'(0);
        hi_sum = low ? (r + r) : (p + r);
        high   = hi_sum >= span;
        v1     = low ? neg_sat16(vel) : vel;
        res.vel = high ? neg_sat16(v1) : v1;
        if (high) begin
            res.pos = sat16(span - r);
        end else if (low) begin
            res.pos = r[15:0];
        end else begin
            res.pos = pos;
        end
        return res;
    endfunction

    // Add velocity to position with 16-bit saturation
    function automatic logic signed [15:0] advance16(input logic signed [15:0] pos,
                                                     input logic signed [15:0] vel);
        logic signed [16:0] s;
        logic signed [15:0] r;
        s = {pos[15], pos} + {vel[15], vel};
        if (s[16] != s[15]) begin
            r = s[16] ? 16'sh8000 : 16'sh7FFF;
        end else begin
            r = s[15:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* hdl/bouncing_circle_sprite_engine.sv */
// Top level of the bouncing circle sprite engine: controller, output register
// and the row of bcs_cell circles. Depends on bcs_pkg and bcs_cell.
//
// One word is worked at a time and each yields one result word. A load or an
// unused operation code goes straight to the result step. A motion tick bounces
// on acceptance, then advances in the tick step, in every cell at once. A pixel
// query waits in the query step for the three-stage squared distance pipeline in
// each cell, followed by the hit word walking the row of cells one cell per
// cycle. A new word is accepted while the previous result still waits in the
// output register; a finished result that finds the output register still full
// holds the input until m_ready frees it.
`default_nettype none

module bouncing_circle_sprite_engine #(
    parameter int CIRCLE_COUNT  = bcs_pkg::CIRCLE_COUNT_DEF,
    parameter int SCREEN_COLS   = bcs_pkg::SCREEN_COLS_DEF,
    parameter int SCREEN_ROWS   = bcs_pkg::SCREEN_ROWS_DEF,
    parameter int FRACTION_BITS = bcs_pkg::FRACTION_BITS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_operation,
    input  wire logic [6:0]         s_pixel_col,
    input  wire logic [4:0]         s_pixel_row,
    input  wire logic [1:0]         s_circle_slot,
    input  wire logic signed [15:0] s_load_pos_x,
    input  wire logic signed [15:0] s_load_pos_y,
    input  wire logic [12:0]        s_load_radius,
    input  wire logic signed [15:0] s_load_vel_x,
    input  wire logic signed [15:0] s_load_vel_y,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_covered,
    output logic [1:0]              m_covering_circle
);

    localparam int CNT_W = $clog2(CIRCLE_COUNT + 3);
    localparam logic [CNT_W-1:0] QDONE = CNT_W'(CIRCLE_COUNT + 2);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_QUERY = 4'b0010,
        ST_TICK  = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    bcs_pkg::hit_t     pend_reg, pend_next;
    logic              m_valid_reg, m_valid_next;
    bcs_pkg::hit_t     out_reg, out_next;
    logic              accept;
    bcs_pkg::cmd_t     cmd;
    bcs_pkg::hit_t     chain [0:CIRCLE_COUNT];

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // Broadcast command to the cells
    always_comb begin
        cmd.query   = accept && (s_operation == bcs_pkg::OP_QUERY);
        cmd.load    = accept && (s_operation == bcs_pkg::OP_LOAD);
        cmd.bounce  = accept && (s_operation == bcs_pkg::OP_TICK);
        cmd.advance = (state_reg == ST_TICK);
        cmd.col     = s_pixel_col;
        cmd.row     = s_pixel_row;
        cmd.slot    = s_circle_slot;
        cmd.pos_x   = s_load_pos_x;
        cmd.pos_y   = s_load_pos_y;
        cmd.radius  = s_load_radius;
        cmd.vel_x   = s_load_vel_x;
        cmd.vel_y   = s_load_vel_y;
    end

    // Row of circle cells
    assign chain[0] = '0;

    for (genvar i = 0; i < CIRCLE_COUNT; i++) begin : g_cell
        bcs_cell #(
            .IDX          (i),
            .SCREEN_COLS  (SCREEN_COLS),
            .SCREEN_ROWS  (SCREEN_ROWS),
            .FRACTION_BITS(FRACTION_BITS)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cmd      (cmd),
            .chain_in (chain[i]),
            .chain_out(chain[i+1])
        );
    end

    // Sequence each word and load the output register
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        pend_next    = pend_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_operation)
                        bcs_pkg::OP_QUERY: begin
                            state_next = ST_QUERY;
                            cnt_next   = '0;
                        end
                        bcs_pkg::OP_TICK: begin
                            state_next = ST_TICK;
                        end
                        default: begin
                            state_next = ST_DONE;
                            pend_next  = '0;
                        end
                    endcase
                end
            end
            ST_QUERY: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == QDONE) begin
                    pend_next  = chain[CIRCLE_COUNT];
                    state_next = ST_DONE;
                end
            end
            ST_TICK: begin
                pend_next  = '0;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    out_next     = pend_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_covered         = out_reg.found;
    assign m_covering_circle = out_reg.idx;

`ifndef NO_ASSERTIONS
    // A tick bounces on acceptance and advances in the next cycle
    a_tick_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_operation == bcs_pkg::OP_TICK) |=> (state_reg == ST_TICK))
        else $error("tick did not enter advance step");

    // A load finishes straight away
    a_load_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_operation == bcs_pkg::OP_LOAD) |=> (state_reg == ST_DONE))
        else $error("load did not go to result step");

    // Query counter never runs past the end of the chain
    a_query_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_QUERY) |-> (cnt_reg <= QDONE))
        else $error("query counter overran");

    // Reported circle is one that exists
    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_reg.found) |->
            ((CIRCLE_COUNT > 4) || (32'(out_reg.idx) < CIRCLE_COUNT)))
        else $error("covering circle index out of range");

    // Non-query results carry no hit; checked here for ticks
    a_pend_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TICK) |=> !pend_reg.found)
        else $error("tick result reported a hit");
`endif

endmodule

`default_nettype wire

/* hdl/bcs_cell.sv */
// One circle of the sprite table: its state, motion update and coverage test.
// Passes the hit word on to the next cell every cycle. Depends on bcs_pkg.
`default_nettype none

module bcs_cell #(
    parameter int IDX           = 0,
    parameter int SCREEN_COLS   = bcs_pkg::SCREEN_COLS_DEF,
    parameter int SCREEN_ROWS   = bcs_pkg::SCREEN_ROWS_DEF,
    parameter int FRACTION_BITS = bcs_pkg::FRACTION_BITS_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire bcs_pkg::cmd_t cmd,
    input  wire bcs_pkg::hit_t chain_in,
    output bcs_pkg::hit_t      chain_out
);

    localparam logic signed [bcs_pkg::SW-1:0] SPAN_X =
        bcs_pkg::SW'(SCREEN_COLS * (2 ** FRACTION_BITS));
    localparam logic signed [bcs_pkg::SW-1:0] SPAN_Y =
        bcs_pkg::SW'(SCREEN_ROWS * (2 ** FRACTION_BITS));
    localparam logic [13:0] RND = 14'((2 ** FRACTION_BITS) - 1);

    // Circle state
    logic signed [15:0] cx_reg, cx_next;
    logic signed [15:0] cy_reg, cy_next;
    logic [12:0]        rad_reg, rad_next;
    logic signed [15:0] vx_reg, vx_next;
    logic signed [15:0] vy_reg, vy_next;

    // Coverage pipeline
    logic signed [bcs_pkg::D_W-1:0]  dx_reg, dy_reg;
    logic [bcs_pkg::CR_W-1:0]        cr_reg;
    logic signed [bcs_pkg::SQ_W-1:0] sqx_reg, sqy_reg;
    logic [2*bcs_pkg::CR_W-1:0]      crsq_reg;
    logic                            hit_reg;
    bcs_pkg::hit_t                   chain_reg, chain_next;

    logic                            slot_match;
    bcs_pkg::axis_t                  bx, by;
    logic signed [bcs_pkg::D_W-1:0]  px, py;
    logic [13:0]                     rad_up;
    logic [bcs_pkg::CMP_W-1:0]       d2, lim;

    assign slot_match = cmd.load && (5'(cmd.slot) == 5'(IDX));

    // Load, bounce and advance
    always_comb begin
        bx      = bcs_pkg::bounce(cx_reg, vx_reg, rad_reg, SPAN_X);
        by      = bcs_pkg::bounce(cy_reg, vy_reg, rad_reg, SPAN_Y);
        cx_next = cx_reg;
        cy_next = cy_reg;
        rad_next = rad_reg;
        vx_next = vx_reg;
        vy_next = vy_reg;
        if (slot_match) begin
            cx_next  = cmd.pos_x;
            cy_next  = cmd.pos_y;
            rad_next = cmd.radius;
            vx_next  = cmd.vel_x;
            vy_next  = cmd.vel_y;
        end else if (cmd.bounce) begin
            cx_next = bx.pos;
            vx_next = bx.vel;
            cy_next = by.pos;
            vy_next = by.vel;
        end else if (cmd.advance) begin
            cx_next = bcs_pkg::advance16(cx_reg, vx_reg);
            cy_next = bcs_pkg::advance16(cy_reg, vy_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cx_reg  <= '0;
            cy_reg  <= '0;
            rad_reg <= '0;
            vx_reg  <= '0;
            vy_reg  <= '0;
        end else begin
            cx_reg  <= cx_next;
            cy_reg  <= cy_next;
            rad_reg <= rad_next;
            vx_reg  <= vx_next;
            vy_reg  <= vy_next;
        end
    end

    // Distance and rounded-up radius
    always_comb begin
        px     = bcs_pkg::D_W'(cmd.col) <<< FRACTION_BITS;
        py     = bcs_pkg::D_W'(cmd.row) <<< FRACTION_BITS;
        rad_up = 14'(rad_reg) + RND;
    end

    always_ff @(posedge aclk) begin
        if (cmd.query) begin
            dx_reg <= px - bcs_pkg::D_W'(cx_reg);
            dy_reg <= py - bcs_pkg::D_W'(cy_reg);
            cr_reg <= bcs_pkg::CR_W'(rad_up >> FRACTION_BITS);
        end
        // Square terms
        sqx_reg  <= dx_reg * dx_reg;
        sqy_reg  <= dy_reg * dy_reg;
        crsq_reg <= cr_reg * cr_reg;
        // Compare
        hit_reg  <= d2 < lim;
    end

    always_comb begin
        d2  = bcs_pkg::CMP_W'(unsigned'(sqx_reg)) + bcs_pkg::CMP_W'(unsigned'(sqy_reg));
        lim = bcs_pkg::CMP_W'(crsq_reg) << (2 * FRACTION_BITS);
    end

    // Keep the earlier cell's hit, else offer our own
    always_comb begin
        if (chain_in.found) begin
            chain_next = chain_in;
        end else if (hit_reg) begin
            chain_next.found = 1'b1;
            chain_next.idx   = 2'(IDX);
        end else begin
            chain_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chain_reg <= '0;
        end else begin
            chain_reg <= chain_next;
        end
    end

    assign chain_out = chain_reg;

endmodule

`default_nettype wire
